// ----- rtl/core/adbr_pkg.sv -----
// ----------------------------------------------------------------------------
// adbr_pkg
// Shared types and constants for the stream table responder.
// ----------------------------------------------------------------------------
package adbr_pkg;

    localparam int unsigned STREAM_SLOTS_DEF = 32;

    localparam logic [31:0] CMD_CNXN = 32'h4e584e43;
    localparam logic [31:0] CMD_OKAY = 32'h59414b4f;
    localparam logic [31:0] CMD_CLSE = 32'h45534c43;
    localparam logic [31:0] CMD_WRTE = 32'h45545257;
    localparam logic [31:0] CMD_OPEN = 32'h4e45504f;
    localparam logic [31:0] CMD_AUTH = 32'h48545541;
    localparam logic [31:0] LINK_VERSION = 32'h01000000;
    localparam logic [31:0] LINK_MAXDATA = 32'h00040000;
    localparam logic [31:0] ALL_ONES = 32'hFFFFFFFF;
    localparam logic [31:0] BASE_RESET = 32'h00001000;

    localparam logic [31:0] AUTH_TYPE_TOKEN = 32'd1;
    localparam logic [31:0] AUTH_SIGN = 32'd2;
    localparam logic [31:0] AUTH_KEY = 32'd3;

    typedef enum logic [2:0] {
        OP_BAD, OP_CNXN, OP_AUTH, OP_OPEN, OP_WRTE, OP_CLSE
    } op_t;

    typedef enum logic [2:0] {
        KIND_FREE, KIND_SHELL, KIND_SYNC, KIND_TCP, KIND_JDWP, KIND_OTHER
    } kind_t;

    typedef enum logic [2:0] {
        SEL_NONE, SEL_PROMPT, SEL_SHELL_RESP, SEL_SYNC_OKAY,
        SEL_CONNECT, SEL_SIGN, SEL_KEY, SEL_TOKEN
    } sel_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DECIDE, ST_SCAN, ST_READ, ST_EMIT1, ST_EMIT2
    } back_state_t;

    // One classified message handed from front to back
    typedef struct packed {
        op_t         op;
        logic [31:0] arg0;
        logic [31:0] arg1;
        logic        present;
        kind_t       kind;
    } job_t;

    // One planned reply header
    typedef struct packed {
        logic [31:0] cmd;
        logic [31:0] arg0;
        logic [31:0] arg1;
        sel_t        sel;
        logic        endc;
    } reply_t;

endpackage

// ----- rtl/core/adbr_front.sv -----
// ----------------------------------------------------------------------------
// adbr_front
// Accepts message headers, tracks session start and classifies each one.
// ----------------------------------------------------------------------------
module adbr_front
    import adbr_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [167:0] s_tdata,
    input  logic         q_full,
    output logic         q_push,
    output job_t         q_data
);

    logic        session_reg;
    logic        session_next;
    logic [31:0] cmd;
    logic [31:0] len;
    logic [39:0] head;
    logic        take;
    logic        auth_ok;
    logic        needs_job;

    assign cmd  = s_tdata[31:0];
    assign len  = s_tdata[127:96];
    assign head = s_tdata[167:128];

    assign s_tready = !q_full;
    assign take     = s_tvalid && s_tready;
    assign auth_ok  = (s_tdata[63:32] == AUTH_TYPE_TOKEN) || (s_tdata[63:32] == AUTH_SIGN) ||
                      (s_tdata[63:32] == AUTH_KEY);

    // Classify the transfer and decide whether the back end sees it
    always_comb begin
        q_data.arg0    = s_tdata[63:32];
        q_data.arg1    = s_tdata[95:64];
        q_data.present = (len != 32'd0) && (len <= LINK_MAXDATA);
        q_data.op      = OP_BAD;
        needs_job      = 1'b0;
        session_next   = session_reg;

        if (len >= 32'd5 && head == 40'h7368656c6c) begin
            q_data.kind = KIND_SHELL;
        end else if (len >= 32'd5 && head == 40'h73796e633a) begin
            q_data.kind = KIND_SYNC;
        end else if (len >= 32'd4 && head[39:8] == 32'h7463703a) begin
            q_data.kind = KIND_TCP;
        end else if (len >= 32'd5 && head == 40'h6a6477703a) begin
            q_data.kind = KIND_JDWP;
        end else begin
            q_data.kind = KIND_OTHER;
        end

        if (!session_reg) begin
            if (cmd == CMD_CNXN) begin
                q_data.op    = OP_CNXN;
                needs_job    = 1'b1;
                session_next = take;
            end else if (cmd == CMD_AUTH) begin
                q_data.op    = OP_AUTH;
                needs_job    = auth_ok;
                session_next = take;
            end else begin
                q_data.op = OP_BAD;
                needs_job = 1'b1;
            end
        end else if (cmd == CMD_OPEN) begin
            q_data.op = OP_OPEN;
            needs_job = q_data.present;
        end else if (cmd == CMD_WRTE) begin
            q_data.op = OP_WRTE;
            needs_job = 1'b1;
        end else if (cmd == CMD_CLSE) begin
            q_data.op = OP_CLSE;
            needs_job = 1'b1;
        end else if (cmd == CMD_AUTH) begin
            q_data.op = OP_AUTH;
            needs_job = auth_ok;
        end

        q_push = take && needs_job;
    end

    // Hold session state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            session_reg <= 1'b0;
        end else begin
            session_reg <= session_next;
        end
    end

endmodule

// ----- rtl/core/adbr_queue.sv -----
// ----------------------------------------------------------------------------
// adbr_queue
// Two-entry job queue between front and back end.
// ----------------------------------------------------------------------------
module adbr_queue
    import adbr_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_data,
    output logic full,
    input  logic pop,
    output logic valid,
    output job_t pop_data
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign valid    = (count_reg != 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Store pushed jobs
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ----- rtl/core/adbr_back.sv -----
// ----------------------------------------------------------------------------
// adbr_back
// Executes jobs against the slot table and drives reply transfers.
// ----------------------------------------------------------------------------
module adbr_back
    import adbr_pkg::*;
#(
    parameter int unsigned STREAM_SLOTS = STREAM_SLOTS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [31:0]  base,
    input  logic         q_valid,
    input  job_t         q_data,
    output logic         q_pop,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,
    output logic [3:0]   m_tuser,
    output logic         m_tlast
);

    localparam int unsigned IDXW = (STREAM_SLOTS > 1) ? $clog2(STREAM_SLOTS) : 1;
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(STREAM_SLOTS - 1);

    back_state_t      state_reg, state_next;
    job_t             job_reg, job_next;
    logic [IDXW-1:0]  scan_reg, scan_next;
    logic [STREAM_SLOTS-1:0] occ_reg, occ_next;
    reply_t           p1_reg, p1_next, p2_reg, p2_next;
    logic             two_reg, two_next;

    logic             out_valid_reg, out_valid_next;
    reply_t           out_reg, out_next;
    logic             out_last_reg, out_last_next;
    logic             out_free;

    logic [34:0]      slot_mem [STREAM_SLOTS];
    logic [34:0]      rd_data_reg;
    logic [IDXW-1:0]  rd_addr;
    logic             mem_we;
    logic [IDXW-1:0]  mem_wa;
    logic [34:0]      mem_wd;

    logic [31:0]      diff;
    logic [IDXW-1:0]  look_idx;
    logic             in_range;
    logic [31:0]      cli;
    kind_t            rd_kind;
    logic [31:0]      scan_dev;

    assign diff     = job_reg.arg1 - base;
    assign look_idx = diff[IDXW-1:0];
    assign in_range = (diff < 32'(STREAM_SLOTS));
    assign cli      = rd_data_reg[31:0];
    assign rd_kind  = kind_t'(rd_data_reg[34:32]);
    assign scan_dev = base + 32'(scan_reg);
    assign out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(out_reg.endc ? 32'd0 : (out_reg.cmd ^ ALL_ONES)),
                       out_reg.arg1, out_reg.arg0, out_reg.cmd};
    assign m_tuser  = {out_reg.endc, out_reg.sel};
    assign m_tlast  = out_last_reg;

    // Sequence one job: decide, scan or look up, then emit replies
    always_comb begin
        state_next     = state_reg;
        job_next       = job_reg;
        scan_next      = scan_reg;
        occ_next       = occ_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        two_next       = two_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_next       = out_reg;
        out_last_next  = out_last_reg;
        q_pop          = 1'b0;
        rd_addr        = look_idx;
        mem_we         = 1'b0;
        mem_wa         = scan_reg;
        mem_wd         = {job_reg.kind, job_reg.arg0};

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    job_next   = q_data;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                two_next   = 1'b0;
                state_next = ST_EMIT1;
                case (job_reg.op)
                    OP_BAD: begin
                        p1_next = '{32'd0, 32'd0, 32'd0, SEL_NONE, 1'b1};
                    end
                    OP_CNXN: begin
                        p1_next = '{CMD_CNXN, LINK_VERSION, LINK_MAXDATA, SEL_CONNECT, 1'b0};
                    end
                    OP_AUTH: begin
                        if (job_reg.arg0 == AUTH_TYPE_TOKEN) begin
                            p1_next = '{CMD_AUTH, 32'd1, 32'd0, SEL_TOKEN, 1'b0};
                        end else if (job_reg.arg0 == AUTH_SIGN) begin
                            p1_next = '{CMD_CNXN, LINK_VERSION, LINK_MAXDATA, SEL_SIGN, 1'b0};
                        end else begin
                            p1_next = '{CMD_CNXN, LINK_VERSION, LINK_MAXDATA, SEL_KEY, 1'b0};
                        end
                    end
                    OP_OPEN: begin
                        scan_next  = '0;
                        state_next = ST_SCAN;
                    end
                    OP_WRTE, OP_CLSE: begin
                        state_next = (in_range && occ_reg[look_idx]) ? ST_READ : ST_IDLE;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SCAN: begin
                if (!occ_reg[scan_reg]) begin
                    mem_we             = 1'b1;
                    occ_next[scan_reg] = 1'b1;
                    p1_next    = '{CMD_OKAY, job_reg.arg0, scan_dev, SEL_NONE, 1'b0};
                    p2_next    = '{CMD_WRTE, scan_dev, job_reg.arg0, SEL_PROMPT, 1'b0};
                    two_next   = (job_reg.kind == KIND_SHELL);
                    state_next = ST_EMIT1;
                end else if (scan_reg == LAST_IDX) begin
                    p1_next    = '{CMD_CLSE, job_reg.arg0, 32'd0, SEL_NONE, 1'b0};
                    state_next = ST_EMIT1;
                end else begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_READ: begin
                state_next = ST_EMIT1;
                if (job_reg.op == OP_CLSE) begin
                    p1_next            = '{CMD_CLSE, cli, job_reg.arg1, SEL_NONE, 1'b0};
                    occ_next[look_idx] = 1'b0;
                end else begin
                    p1_next  = '{CMD_OKAY, cli, job_reg.arg1, SEL_NONE, 1'b0};
                    two_next = job_reg.present &&
                               (rd_kind == KIND_SHELL || rd_kind == KIND_SYNC);
                    p2_next  = '{CMD_WRTE, job_reg.arg1, cli,
                                 (rd_kind == KIND_SHELL) ? SEL_SHELL_RESP : SEL_SYNC_OKAY,
                                 1'b0};
                end
            end
            ST_EMIT1: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_next       = p1_reg;
                    out_last_next  = !two_reg;
                    state_next     = two_reg ? ST_EMIT2 : ST_IDLE;
                end
            end
            ST_EMIT2: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_next       = p2_reg;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        job_reg      <= job_next;
        scan_reg     <= scan_next;
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        two_reg      <= two_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    // Slot table: kind and client id
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= slot_mem[rd_addr];
    end

endmodule

// ----- rtl/core/adb_stream_table_responder.sv -----
// ----------------------------------------------------------------------------
// adb_stream_table_responder
// Device-side stream table responder for a multiplexed link protocol.
// ----------------------------------------------------------------------------
// Each accepted header yields zero, one or two reply headers. The front end
// classifies a header in the cycle it is accepted and queues it (two deep);
// the back end handles one job at a time: it takes the job from the queue,
// decides on it, reads the slot table for WRTE and CLSE, and emits each reply
// in turn, waiting until the reply register is free. OPEN scans the occupancy
// bits one slot per cycle and stops at the lowest free slot, or at the last
// slot if all are taken. The reply register frees the back end as soon as
// a reply is taken.
module adb_stream_table_responder
    import adbr_pkg::*;
#(
    parameter int unsigned STREAM_SLOTS = STREAM_SLOTS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata,     // device_id_base
    input  logic         s_tvalid,
    output logic         s_tready,
    // msg_command, first_arg, second_arg, payload_length, payload_head
    input  logic [167:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_command, out_first_arg, out_second_arg, out_check
    output logic [127:0] m_tdata,
    // payload_select, end_connection
    output logic [3:0]   m_tuser,
    output logic         m_tlast
);

    logic [31:0] base_reg;
    logic        q_full;
    logic        q_push;
    logic        q_valid;
    logic        q_pop;
    job_t        push_job;
    job_t        pop_job;

    // Hold the device id base
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= BASE_RESET;
        end else if (cfg_we) begin
            base_reg <= cfg_wdata;
        end
    end

    adbr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (push_job)
    );

    adbr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (pop_job)
    );

    adbr_back #(
        .STREAM_SLOTS (STREAM_SLOTS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .base     (base_reg),
        .q_valid  (q_valid),
        .q_data   (pop_job),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
